// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the framed checksum receiver.
// Expects clk and rst_n (synchronous, active low) in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define FCR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("framed_checksum_receiver: assertion failed");
`define FCR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framed_checksum_receiver: assertion failed");
`else
`define FCR_ASSERT(lbl, prop)
`define FCR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/fcr_pkg.sv =====
// Package of the framed checksum receiver: framing characters, result status
// codes, controller states and the 6-bit digit unpacking function. No dependencies.
`default_nettype none
package fcr_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int MIN_FRAME       = 5;
  localparam int MIN_GROUP_FRAME = 9;
  localparam int FIRST_DIGIT     = 3;
  localparam int SUM_W           = 12;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_R    = 8'h52;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_CRC = 2'd1,
    ST_OVR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_CK1,
    S_RD_CK2,
    S_RD_CMD,
    S_RD_ADDR,
    S_CHECK,
    S_ERR,
    S_EMPTY,
    S_GRP_RD,
    S_GRP_LAST,
    S_GRP_OUT
  } fsm_t;

  function automatic logic [7:0] fcr_unpack(input logic [1:0] sel,
                                            input logic [7:0] a,
                                            input logic [7:0] b,
                                            input logic [7:0] c,
                                            input logic [7:0] d);
    logic [7:0] v;
    unique case (sel)
      2'd0:    v = {a[5:0], 2'b00} | {4'b0000, b[7:4]};
      2'd1:    v = {b[3:0], 4'b0000} | {2'b00, c[7:2]};
      default: v = {c[1:0], 6'b000000} | d;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/framed_checksum_receiver.sv =====
// Top level of the framed checksum receiver: command register, frame RAM and
// frame controller. Uses fcr_pkg, fcr_ram, fcr_ctrl and assert_macros.svh.
//
// Usage: bytes enter on in_rx_byte with in_valid/in_ready; results leave on
// the out_ channel with out_valid/out_ready, one per item, the final one of a
// frame marked by out_last. cfg_wr_en/cfg_wr_data set the expected command.
// Ordinary frame bytes are written to the frame RAM as they are accepted, and
// in_ready stays high. At the terminator the controller reads the two check
// characters, the command and the address from the RAM (S_RD_CK1 to S_CHECK),
// then reads the four digits of each digit group and offers its three bytes
// one by one; in_ready is low until the last result of the frame is in the
// output register. Checksum errors and overruns give one result each. The
// frame RAM has a single read port, so its reads are made one after another.
// Reset clears the fill count, sum, error counters, command register and the
// output valid flag; the frame RAM needs no clearing. When the receiver stalls,
// the output register holds its item and the controller waits at the next
// result with in_ready low; bytes are taken again once the last result of
// the frame is in the output register.
`default_nettype none
`include "assert_macros.svh"
module framed_checksum_receiver
  import fcr_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic             out_has_data,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_address_char,
  output logic [7:0]       out_command_char,
  output logic             out_reset_request,
  output logic             out_last,
  output logic [15:0]      out_crc_error_total,
  output logic [15:0]      out_overrun_total
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(FRAME_BYTES);

  logic [7:0]    exp_cmd_r;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [FW-1:0] mon_fill;
  logic [15:0]   mon_crc_count;
  logic          idle_drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cmd_r <= 8'd0;
    end else if (cfg_wr_en) begin
      exp_cmd_r <= cfg_wr_data;
    end
  end

  fcr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fcr_ctrl #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .expected_command    (exp_cmd_r),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_has_data        (out_has_data),
    .out_data_byte       (out_data_byte),
    .out_address_char    (out_address_char),
    .out_command_char    (out_command_char),
    .out_reset_request   (out_reset_request),
    .out_last            (out_last),
    .out_crc_error_total (out_crc_error_total),
    .out_overrun_total   (out_overrun_total),
    .ram_we              (ram_we),
    .ram_waddr           (ram_waddr),
    .ram_wdata           (ram_wdata),
    .ram_raddr           (ram_raddr),
    .ram_rdata           (ram_rdata),
    .mon_fill            (mon_fill),
    .mon_crc_count       (mon_crc_count)
  );

  assign idle_drop = in_valid && in_ready && (mon_fill == '0) && (in_rx_byte != CH_HASH);

  `FCR_ASSERT(a_fill_bound, mon_fill <= FILL_MAX)
  `FCR_ASSERT_NXT(a_idle_drop, idle_drop, mon_fill == '0)
  `FCR_ASSERT(a_crc_step, !$past(rst_n) || (mon_crc_count - $past(mon_crc_count) <= 16'd1))
  `FCR_ASSERT(a_err_last, (out_valid && (out_status != ST_OK)) |-> out_last)

endmodule
`default_nettype wire

// ===== hdl/fcr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/fcr_ctrl.sv =====
// Frame controller: stores frame bytes in the frame RAM, checks the frame at
// the terminator, unpacks digit groups and drives the result register. Uses fcr_pkg.
`default_nettype none
module fcr_ctrl
  import fcr_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int AW = $clog2(FRAME_BYTES),
  localparam int FW = $clog2(FRAME_BYTES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [7:0]    expected_command,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_status,
  output logic               out_has_data,
  output logic [7:0]         out_data_byte,
  output logic [7:0]         out_address_char,
  output logic [7:0]         out_command_char,
  output logic               out_reset_request,
  output logic               out_last,
  output logic [15:0]        out_crc_error_total,
  output logic [15:0]        out_overrun_total,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [7:0]         ram_wdata,
  output logic [AW-1:0]      ram_raddr,
  input  wire logic [7:0]    ram_rdata,
  output logic [FW-1:0]      mon_fill,
  output logic [15:0]        mon_crc_count
);

  fsm_t            state_r, state_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [FW-1:0]   n_r, n_nxt;
  logic [FW-1:0]   p_r, p_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [1:0]      bsel_r, bsel_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [15:0]     ovr_r, ovr_nxt;
  status_t         err_r, err_nxt;
  logic [7:0]      ck1_r, ck1_nxt;
  logic [7:0]      ck2_r, ck2_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [7:0]      addr_r, addr_nxt;
  logic            pend_r;
  logic [1:0]      pidx_r;
  logic [7:0]      dig_r [4];

  logic            out_valid_r, out_valid_nxt;
  status_t         o_status_r, o_status_nxt;
  logic            o_has_r, o_has_nxt;
  logic [7:0]      o_data_r, o_data_nxt;
  logic [7:0]      o_addr_r, o_addr_nxt;
  logic [7:0]      o_cmd_r, o_cmd_nxt;
  logic            o_rst_r, o_rst_nxt;
  logic            o_last_r, o_last_nxt;
  logic [15:0]     o_crc_r, o_crc_nxt;
  logic [15:0]     o_ovr_r, o_ovr_nxt;

  logic            acc;
  logic            out_free;
  logic [SUM_W-1:0] chk_s;
  logic            chk_ok;
  logic            grp_last;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign chk_s    = sum_r - {{(SUM_W-8){1'b0}}, ck1_r} - {{(SUM_W-8){1'b0}}, ck2_r};
  assign chk_ok   = (ck1_r == CH_EQ + {2'b00, chk_s[11:6]}) &&
                    (ck2_r == CH_EQ + {2'b00, chk_s[5:0]});
  assign grp_last = ({1'b0, p_r} + (FW+1)'(10)) > {1'b0, n_r};

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    bsel_nxt      = bsel_r;
    sum_nxt       = sum_r;
    crc_nxt       = crc_r;
    ovr_nxt       = ovr_r;
    err_nxt       = err_r;
    ck1_nxt       = ck1_r;
    ck2_nxt       = ck2_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_status_nxt  = o_status_r;
    o_has_nxt     = o_has_r;
    o_data_nxt    = o_data_r;
    o_addr_nxt    = o_addr_r;
    o_cmd_nxt     = o_cmd_r;
    o_rst_nxt     = o_rst_r;
    o_last_nxt    = o_last_r;
    o_crc_nxt     = o_crc_r;
    o_ovr_nxt     = o_ovr_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_r[AW-1:0];
    ram_wdata     = in_rx_byte;
    ram_raddr     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority if (fill_r == '0) begin
            if (in_rx_byte == CH_HASH) begin
              ram_we   = 1'b1;
              sum_nxt  = {{(SUM_W-8){1'b0}}, in_rx_byte};
              fill_nxt = FW'(1);
            end
          end else if (fill_r == FW'(FRAME_BYTES)) begin
            ovr_nxt   = ovr_r + 16'd1;
            fill_nxt  = '0;
            err_nxt   = ST_OVR;
            state_nxt = S_ERR;
          end else if (in_rx_byte != CH_CR) begin
            ram_we   = 1'b1;
            sum_nxt  = sum_r + {{(SUM_W-8){1'b0}}, in_rx_byte};
            fill_nxt = fill_r + FW'(1);
          end else begin
            n_nxt    = fill_r;
            fill_nxt = '0;
            if (fill_r < FW'(MIN_FRAME)) begin
              crc_nxt   = crc_r + 16'd1;
              err_nxt   = ST_CRC;
              state_nxt = S_ERR;
            end else begin
              state_nxt = S_RD_CK1;
            end
          end
        end
      end
      S_RD_CK1: begin
        ram_raddr = AW'(n_r - FW'(2));
        state_nxt = S_RD_CK2;
      end
      S_RD_CK2: begin
        ram_raddr = AW'(n_r - FW'(1));
        ck1_nxt   = ram_rdata;
        state_nxt = S_RD_CMD;
      end
      S_RD_CMD: begin
        ram_raddr = AW'(2);
        ck2_nxt   = ram_rdata;
        state_nxt = S_RD_ADDR;
      end
      S_RD_ADDR: begin
        ram_raddr = AW'(1);
        cmd_nxt   = ram_rdata;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        addr_nxt = ram_rdata;
        priority if (!chk_ok) begin
          crc_nxt   = crc_r + 16'd1;
          err_nxt   = ST_CRC;
          state_nxt = S_ERR;
        end else if (cmd_r != expected_command) begin
          state_nxt = S_IDLE;
        end else if (n_r < FW'(MIN_GROUP_FRAME)) begin
          state_nxt = S_EMPTY;
        end else begin
          p_nxt     = FW'(FIRST_DIGIT);
          cnt_nxt   = 2'd0;
          state_nxt = S_GRP_RD;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = err_r;
          o_has_nxt     = 1'b0;
          o_data_nxt    = 8'd0;
          o_addr_nxt    = 8'd0;
          o_cmd_nxt     = 8'd0;
          o_rst_nxt     = 1'b0;
          o_last_nxt    = 1'b1;
          o_crc_nxt     = crc_r;
          o_ovr_nxt     = ovr_r;
          state_nxt     = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = ST_OK;
          o_has_nxt     = 1'b0;
          o_data_nxt    = 8'd0;
          o_addr_nxt    = addr_r;
          o_cmd_nxt     = cmd_r;
          o_rst_nxt     = (cmd_r == CH_R);
          o_last_nxt    = 1'b1;
          o_crc_nxt     = crc_r;
          o_ovr_nxt     = ovr_r;
          state_nxt     = S_IDLE;
        end
      end
      S_GRP_RD: begin
        ram_raddr = AW'(p_r + FW'(cnt_r));
        cnt_nxt   = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = S_GRP_LAST;
        end
      end
      S_GRP_LAST: begin
        bsel_nxt  = 2'd0;
        state_nxt = S_GRP_OUT;
      end
      S_GRP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt  = ST_OK;
          o_has_nxt     = 1'b1;
          o_data_nxt    = fcr_unpack(bsel_r, dig_r[0], dig_r[1], dig_r[2], dig_r[3]);
          o_addr_nxt    = addr_r;
          o_cmd_nxt     = cmd_r;
          o_rst_nxt     = (cmd_r == CH_R);
          o_last_nxt    = (bsel_r == 2'd2) && grp_last;
          o_crc_nxt     = crc_r;
          o_ovr_nxt     = ovr_r;
          if (bsel_r == 2'd2) begin
            if (grp_last) begin
              state_nxt = S_IDLE;
            end else begin
              p_nxt     = p_r + FW'(4);
              cnt_nxt   = 2'd0;
              state_nxt = S_GRP_RD;
            end
          end else begin
            bsel_nxt = bsel_r + 2'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      sum_r       <= '0;
      crc_r       <= '0;
      ovr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      crc_r       <= crc_nxt;
      ovr_r       <= ovr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= (state_r == S_GRP_RD);
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    p_r        <= p_nxt;
    cnt_r      <= cnt_nxt;
    bsel_r     <= bsel_nxt;
    err_r      <= err_nxt;
    ck1_r      <= ck1_nxt;
    ck2_r      <= ck2_nxt;
    cmd_r      <= cmd_nxt;
    addr_r     <= addr_nxt;
    pidx_r     <= cnt_r;
    o_status_r <= o_status_nxt;
    o_has_r    <= o_has_nxt;
    o_data_r   <= o_data_nxt;
    o_addr_r   <= o_addr_nxt;
    o_cmd_r    <= o_cmd_nxt;
    o_rst_r    <= o_rst_nxt;
    o_last_r   <= o_last_nxt;
    o_crc_r    <= o_crc_nxt;
    o_ovr_r    <= o_ovr_nxt;
    if (pend_r) begin
      dig_r[pidx_r] <= ram_rdata - CH_EQ;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_has_data        = o_has_r;
  assign out_data_byte       = o_data_r;
  assign out_address_char    = o_addr_r;
  assign out_command_char    = o_cmd_r;
  assign out_reset_request   = o_rst_r;
  assign out_last            = o_last_r;
  assign out_crc_error_total = o_crc_r;
  assign out_overrun_total   = o_ovr_r;
  assign mon_fill            = fill_r;
  assign mon_crc_count       = crc_r;

endmodule
`default_nettype wire

// ===== tb/frame_result_check.sv =====
// Result checker for the framed checksum receiver: follows the input, config and result
// channels, predicts every result from the accepted bytes and compares them in order.
// Depends on fcr_pkg for the framing characters and the status codes.
`timescale 1ns / 100ps
module frame_result_check
  import fcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic        out_has_data,
  input  logic [7:0]  out_data_byte,
  input  logic [7:0]  out_address_char,
  input  logic [7:0]  out_command_char,
  input  logic        out_reset_request,
  input  logic        out_last,
  input  logic [15:0] out_crc_error_total,
  input  logic [15:0] out_overrun_total,
  output int          mismatches,
  output int          outstanding
);

  localparam int FRAME_LEN = FRAME_BYTES_DEF;

  typedef struct packed {
    status_t     status;
    logic        has_data;
    logic [7:0]  data_byte;
    logic [7:0]  address_char;
    logic [7:0]  command_char;
    logic        reset_request;
    logic        last;
    logic [15:0] crc_total;
    logic [15:0] ovr_total;
  } rx_result_t;

  rx_result_t  pending_results[$];
  logic [7:0]  wanted_cmd;
  logic [7:0]  frame_copy [FRAME_LEN];
  int          stored;
  logic [15:0] byte_sum;
  logic [15:0] crc_errors;
  logic [15:0] overruns;

  task automatic post_result(input status_t st, input logic has, input logic [7:0] data,
                             input logic [7:0] addr, input logic [7:0] cmd,
                             input logic rst_req, input logic fin);
    rx_result_t r;
    r.status        = st;
    r.has_data      = has;
    r.data_byte     = data;
    r.address_char  = addr;
    r.command_char  = cmd;
    r.reset_request = rst_req;
    r.last          = fin;
    r.crc_total     = crc_errors;
    r.ovr_total     = overruns;
    pending_results.push_back(r);
  endtask

  task automatic track_rx_byte(input logic [7:0] b);
    int          n;
    int          groups;
    int          p;
    logic [15:0] s;
    logic [7:0]  ck1, ck2, addr, cmd;
    logic [7:0]  d0, d1, d2, d3;
    logic        rst_req;
    if (stored == 0) begin
      if (b == CH_HASH) begin
        frame_copy[0] = b;
        byte_sum = {8'h00, b};
        stored = 1;
      end
    end else if (stored >= FRAME_LEN) begin
      overruns = overruns + 16'd1;
      stored = 0;
      post_result(ST_OVR, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
    end else if (b != CH_CR) begin
      frame_copy[stored] = b;
      byte_sum = byte_sum + {8'h00, b};
      stored++;
    end else begin
      n = stored;
      stored = 0;
      if (n < 5) begin
        crc_errors = crc_errors + 16'd1;
        post_result(ST_CRC, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
      end else begin
        ck1 = frame_copy[n - 2];
        ck2 = frame_copy[n - 1];
        s = (byte_sum - {8'h00, ck1} - {8'h00, ck2}) & 16'h0FFF;
        if (ck1 != CH_EQ + {2'b00, s[11:6]} || ck2 != CH_EQ + {2'b00, s[5:0]}) begin
          crc_errors = crc_errors + 16'd1;
          post_result(ST_CRC, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
        end else if (frame_copy[2] == wanted_cmd) begin
          addr    = frame_copy[1];
          cmd     = frame_copy[2];
          rst_req = (cmd == CH_R);
          groups  = (n - 5) / 4;
          if (groups == 0)
            post_result(ST_OK, 1'b0, 8'h00, addr, cmd, rst_req, 1'b1);
          for (int g = 0; g < groups; g++) begin
            p  = 3 + 4 * g;
            d0 = frame_copy[p] - CH_EQ;
            d1 = frame_copy[p + 1] - CH_EQ;
            d2 = frame_copy[p + 2] - CH_EQ;
            d3 = frame_copy[p + 3] - CH_EQ;
            post_result(ST_OK, 1'b1, (d0 << 2) | (d1 >> 4), addr, cmd, rst_req, 1'b0);
            post_result(ST_OK, 1'b1, (d1 << 4) | (d2 >> 2), addr, cmd, rst_req, 1'b0);
            post_result(ST_OK, 1'b1, (d2 << 6) | d3, addr, cmd, rst_req, g == groups - 1);
          end
        end
      end
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    rx_result_t w;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %h data %h",
               $time, out_status, out_data_byte);
      mismatches++;
    end else begin
      w = pending_results.pop_front();
      check_field("status", 16'(w.status), 16'(out_status));
      check_field("has_data", 16'(w.has_data), 16'(out_has_data));
      check_field("data_byte", 16'(w.data_byte), 16'(out_data_byte));
      check_field("address_char", 16'(w.address_char), 16'(out_address_char));
      check_field("command_char", 16'(w.command_char), 16'(out_command_char));
      check_field("reset_request", 16'(w.reset_request), 16'(out_reset_request));
      check_field("last", 16'(w.last), 16'(out_last));
      check_field("crc_error_total", w.crc_total, out_crc_error_total);
      check_field("overrun_total", w.ovr_total, out_overrun_total);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      wanted_cmd = 8'h00;
      stored     = 0;
      byte_sum   = 16'h0000;
      crc_errors = 16'h0000;
      overruns   = 16'h0000;
    end else begin
      if (cfg_wr_en)
        wanted_cmd = cfg_wr_data;
      if (in_valid && in_ready)
        track_rx_byte(in_rx_byte);
      if (out_valid && out_ready)
        check_result();
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the framed checksum receiver: clock, reset, byte and config stimulus,
// receiver back-pressure and the verdict. Depends on fcr_pkg and frame_result_check.
`timescale 1ns / 100ps
module tb;
  import fcr_pkg::*;

  localparam int FRAME_LEN     = FRAME_BYTES_DEF;
  localparam int SETTLE_CYCLES = 200;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_has_data;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_address_char;
  logic [7:0]  out_command_char;
  logic        out_reset_request;
  logic        out_last;
  logic [15:0] out_crc_error_total;
  logic [15:0] out_overrun_total;
  int          mismatches;
  int          outstanding;

  rx_mode_t    rx_mode = RX_ALWAYS;
  int          rx_span = 0;
  logic [7:0]  rx_pattern = 8'b1011_0010;
  int          burst_left = 0;
  logic        in_held = 1'b0;
  int          bytes_sent = 0;
  logic [7:0]  cur_cmd = 8'h00;

  framed_checksum_receiver DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_has_data        (out_has_data),
    .out_data_byte       (out_data_byte),
    .out_address_char    (out_address_char),
    .out_command_char    (out_command_char),
    .out_reset_request   (out_reset_request),
    .out_last            (out_last),
    .out_crc_error_total (out_crc_error_total),
    .out_overrun_total   (out_overrun_total)
  );

  frame_result_check checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_span <= $urandom_range(16, 200);
    end else begin
      rx_span <= rx_span - 1;
    end
    rx_pattern <= {rx_pattern[6:0], rx_pattern[7]};
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= rx_pattern[0];
    endcase
  end

  function automatic logic [7:0] pick_non_cr();
    logic [7:0] v;
    v = 8'($urandom);
    if (v == CH_CR)
      v = ~v;
    return v;
  endfunction

  function automatic byte_q_t make_digits(input int len, input bit wild);
    byte_q_t q;
    for (int i = 0; i < len; i++) begin
      if (wild && $urandom_range(0, 1) == 0)
        q.push_back(pick_non_cr());
      else
        q.push_back(CH_EQ + 8'($urandom_range(0, 63)));
    end
    return q;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    in_held = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
      in_valid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input byte_q_t body, input logic [7:0] check_flip);
    byte_q_t     pkt;
    logic [15:0] s;
    pkt = {CH_HASH, addr, cmd};
    foreach (body[i]) pkt.push_back(body[i]);
    s = 16'h0000;
    foreach (pkt[i]) s = s + {8'h00, pkt[i]};
    pkt.push_back((CH_EQ + {2'b00, s[11:6]}) ^ check_flip);
    pkt.push_back(CH_EQ + {2'b00, s[5:0]});
    pkt.push_back(CH_CR);
    foreach (pkt[i]) push_byte(pkt[i]);
  endtask

  task automatic drain();
    if (in_held) begin
      in_valid <= 1'b0;
      in_held = 1'b0;
    end
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_cmd = v;
  endtask

  task automatic run_random(input int count);
    int      stop_at;
    int      kind;
    int      len;
    byte_q_t body;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 59) : $urandom_range(0, 16);
      body = make_digits(len, $urandom_range(0, 4) == 0);
      if (kind < 60) begin
        send_frame(pick_non_cr(), ($urandom_range(0, 3) != 0) ? cur_cmd : pick_non_cr(),
                   body, 8'h00);
      end else if (kind < 70) begin
        send_frame(pick_non_cr(), cur_cmd, body, 8'($urandom_range(1, 255)));
      end else if (kind < 78) begin
        push_byte(CH_HASH);
        repeat ($urandom_range(0, 3)) push_byte(pick_non_cr());
        push_byte(CH_CR);
      end else if (kind < 84) begin
        push_byte(CH_HASH);
        repeat (FRAME_LEN - 1) push_byte(pick_non_cr());
        push_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        push_byte(CH_CR);
      end
    end
  endtask

  initial begin
    byte_q_t    body;
    logic [7:0] next_cmd [5];
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'h00;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // drop idle bytes ahead of a frame
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_CR);
    body = {};
    send_frame(8'h00, 8'h00, body, 8'h00);
    body = {CH_EQ, CH_EQ, CH_EQ, CH_EQ, 8'h7C, 8'h7C, 8'h7C, 8'h7C};
    send_frame(8'hFF, 8'h00, body, 8'h00);
    body = {8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h3C, 8'h01, 8'hFE, 8'h3D, 8'h41};
    send_frame(8'h41, 8'h00, body, 8'h00);
    body = {CH_HASH, CH_EQ, 8'h3E, 8'h3F};
    send_frame(CH_HASH, 8'h00, body, 8'h00);
    send_frame(8'h42, 8'h00, make_digits(4, 0), 8'h01);
    send_frame(8'h43, CH_R, make_digits(4, 0), 8'h00);
    push_byte(CH_HASH);
    push_byte(CH_CR);
    push_byte(CH_HASH);
    push_byte(8'h61);
    push_byte(8'h62);
    push_byte(8'h63);
    push_byte(CH_CR);
    send_frame(8'h44, 8'h00, make_digits(58, 0), 8'h00);
    send_frame(8'h45, 8'h00, make_digits(59, 0), 8'h00);
    push_byte(CH_HASH);
    repeat (FRAME_LEN - 1) push_byte(pick_non_cr());
    push_byte(8'h41);
    run_random(6);

    next_cmd = '{CH_R, 8'hFF, 8'($urandom), 8'($urandom), 8'h00};
    foreach (next_cmd[i]) begin
      drain();
      cfg_write(next_cmd[i]);
      send_frame(pick_non_cr(), cur_cmd, make_digits(8, 0), 8'h00);
      run_random(6);
    end
    drain();

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fcr_pkg.sv
hdl/fcr_ram.sv
hdl/fcr_ctrl.sv
hdl/framed_checksum_receiver.sv
tb/frame_result_check.sv
tb/tb.sv
